/* hw/rtl/cmds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter package
// Shared types, constants and the segment decoder for the display shifter.
// ----------------------------------------------------------------------------
package cmds_pkg;

    localparam int SECS_W = 13;
    localparam int TPS_W  = 16;
    localparam int CFG_W  = 16;
    localparam int POS_W  = 3;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 4;

    localparam logic CFG_START_SECONDS    = 1'b0;
    localparam logic CFG_TICKS_PER_SECOND = 1'b1;

    localparam logic [SECS_W-1:0] MAX_START   = 13'd5999;
    localparam logic [SECS_W-1:0] RESET_START = 13'd300;
    localparam logic [TPS_W-1:0]  RESET_TPS   = 16'd1000;
    localparam logic [7:0]        BLANK_SEG   = 8'hFF;
    localparam logic [CNT_W-1:0]  LAST_BIT    = 4'd15;

    typedef enum logic [2:0] {
        CONV_IDLE,
        CONV_MINS,
        CONV_SECS,
        CONV_TENS,
        CONV_UNITS
    } conv_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic [SECS_W-1:0] secs;
    } cmds_item_t;

    function automatic logic [7:0] seg_decode(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hC0;
        endcase
        return seg;
    endfunction

endpackage

/* hw/rtl/countdown_mux_display_shifter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter
// Multiplexed seven-segment countdown timer: one scan word per tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    tick
// out       output     out_valid / out_ready  serial_bit, latch_now,
//                                             scan_position, seconds_left
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// Each tick with tick set yields sixteen output beats; the shifter emits one
// beat per cycle while out_ready is high, and ticks are taken at its pace.
// Ticks with tick clear are taken and produce nothing.
// A start_seconds write holds in_ready low while the digits
// are converted. Reset loads 05:00 and a rate of 1000 ticks per second.
// Output stalls back up through a two-entry queue to in_ready.
// ----------------------------------------------------------------------------
module countdown_mux_display_shifter #(
    parameter int NUM_POSITIONS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cmds_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        tick,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        serial_bit,
    output logic                        latch_now,
    output logic [cmds_pkg::POS_W-1:0]  scan_position,
    output logic [cmds_pkg::SECS_W-1:0] seconds_left
);

    logic                 push;
    logic                 pop;
    logic                 q_ready;
    logic                 q_valid;
    cmds_pkg::cmds_item_t push_item;
    cmds_pkg::cmds_item_t head_item;

    cmds_front #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tick      (tick),
        .push      (push),
        .q_ready   (q_ready),
        .push_item (push_item)
    );

    cmds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    cmds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_bit    (serial_bit),
        .latch_now     (latch_now),
        .scan_position (scan_position),
        .seconds_left  (seconds_left)
    );

endmodule

/* hw/rtl/cmds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter front end
// Accepts ticks, builds the 16-bit scan word, keeps the countdown and digits.
// ----------------------------------------------------------------------------
module cmds_front #(
    parameter int NUM_POSITIONS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [cmds_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          tick,
    output logic                          push,
    input  logic                          q_ready,
    output cmds_pkg::cmds_item_t          push_item
);

    localparam logic [cmds_pkg::POS_W-1:0] LAST_POS = cmds_pkg::POS_W'(NUM_POSITIONS - 1);

    cmds_pkg::conv_state_t state_reg, state_next;

    logic [cmds_pkg::POS_W-1:0]  scan_index_reg, scan_index_next;
    logic [cmds_pkg::TPS_W-1:0]  tick_count_reg, tick_count_next;
    logic [cmds_pkg::TPS_W-1:0]  tps_reg, tps_next;
    logic [cmds_pkg::SECS_W-1:0] remaining_reg, remaining_next;
    logic [3:0]                  digits_reg [4];
    logic [3:0]                  digits_next [4];
    logic [6:0]                  mins_reg, mins_next;
    logic [5:0]                  secs_reg, secs_next;
    logic [3:0]                  mtens_reg, mtens_next;
    logic [3:0]                  stens_reg, stens_next;

    logic                        accept;
    logic [cmds_pkg::SECS_W-1:0] load_val;
    logic [26:0]                 mins_prod;
    logic [cmds_pkg::SECS_W-1:0] secs_full;
    logic [14:0]                 mt_prod;
    logic [13:0]                 st_prod;
    logic [cmds_pkg::TPS_W-1:0]  count_inc;
    logic [cmds_pkg::TPS_W-1:0]  limit;
    logic [7:0]                  sel_byte;
    logic [7:0]                  seg_byte;

    assign in_ready = (state_reg == cmds_pkg::CONV_IDLE) && q_ready;
    assign accept   = in_valid && in_ready;
    assign push     = accept && tick;

    assign load_val  = (cfg_data[cmds_pkg::SECS_W-1:0] > cmds_pkg::MAX_START)
                       ? cmds_pkg::MAX_START : cfg_data[cmds_pkg::SECS_W-1:0];
    assign mins_prod = {14'b0, remaining_reg} * 27'd17477;
    assign secs_full = remaining_reg - {mins_reg, 6'b0} + {4'b0, mins_reg, 2'b0};
    assign mt_prod   = {8'b0, mins_reg} * 15'd205;
    assign st_prod   = {8'b0, secs_reg} * 14'd205;
    assign count_inc = tick_count_reg + 16'd1;
    assign limit     = (tps_reg == '0) ? 16'd1 : tps_reg;

    assign sel_byte = ~(8'h01 << scan_index_reg);
    assign seg_byte = scan_index_reg[2] ? cmds_pkg::BLANK_SEG
                      : cmds_pkg::seg_decode(digits_reg[scan_index_reg[1:0]]);

    assign push_item.word = {sel_byte, seg_byte};
    assign push_item.pos  = scan_index_reg;
    assign push_item.secs = remaining_reg;

    always_comb
    begin
        state_next      = state_reg;
        scan_index_next = scan_index_reg;
        tick_count_next = tick_count_reg;
        tps_next        = tps_reg;
        remaining_next  = remaining_reg;
        digits_next     = digits_reg;
        mins_next       = mins_reg;
        secs_next       = secs_reg;
        mtens_next      = mtens_reg;
        stens_next      = stens_reg;

        case (state_reg)
            cmds_pkg::CONV_IDLE:
            begin
                state_next = cmds_pkg::CONV_IDLE;
            end
            cmds_pkg::CONV_MINS:
            begin
                mins_next  = mins_prod[26:20];
                state_next = cmds_pkg::CONV_SECS;
            end
            cmds_pkg::CONV_SECS:
            begin
                secs_next  = secs_full[5:0];
                state_next = cmds_pkg::CONV_TENS;
            end
            cmds_pkg::CONV_TENS:
            begin
                mtens_next = mt_prod[14:11];
                stens_next = {1'b0, st_prod[13:11]};
                state_next = cmds_pkg::CONV_UNITS;
            end
            cmds_pkg::CONV_UNITS:
            begin
                digits_next[0] = mtens_reg;
                digits_next[1] = 4'(mins_reg - {mtens_reg, 3'b0} - {2'b0, mtens_reg, 1'b0});
                digits_next[2] = stens_reg;
                digits_next[3] = 4'({1'b0, secs_reg} - {1'b0, stens_reg[2:0], 3'b0}
                                 - {2'b0, stens_reg, 1'b0});
                state_next     = cmds_pkg::CONV_IDLE;
            end
            default:
            begin
                state_next = cmds_pkg::CONV_IDLE;
            end
        endcase

        if (accept && tick)
        begin
            scan_index_next = (scan_index_reg >= LAST_POS) ? '0 : scan_index_reg + 3'd1;
            tick_count_next = count_inc;
            if ((count_inc >= limit) || (count_inc == '0))
            begin
                tick_count_next = '0;
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - 13'd1;
                    if (digits_reg[3] != 4'd0)
                    begin
                        digits_next[3] = digits_reg[3] - 4'd1;
                    end
                    else
                    begin
                        digits_next[3] = 4'd9;
                        if (digits_reg[2] != 4'd0)
                        begin
                            digits_next[2] = digits_reg[2] - 4'd1;
                        end
                        else
                        begin
                            digits_next[2] = 4'd5;
                            if (digits_reg[1] != 4'd0)
                            begin
                                digits_next[1] = digits_reg[1] - 4'd1;
                            end
                            else
                            begin
                                digits_next[1] = 4'd9;
                                digits_next[0] = digits_reg[0] - 4'd1;
                            end
                        end
                    end
                end
            end
        end

        if (cfg_we)
        begin
            if (cfg_index == cmds_pkg::CFG_START_SECONDS)
            begin
                remaining_next = load_val;
                state_next     = cmds_pkg::CONV_MINS;
            end
            else
            begin
                tps_next = cfg_data[cmds_pkg::TPS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cmds_pkg::CONV_IDLE;
            scan_index_reg <= '0;
            tick_count_reg <= '0;
            tps_reg        <= cmds_pkg::RESET_TPS;
            remaining_reg  <= cmds_pkg::RESET_START;
            digits_reg[0]  <= 4'd0;
            digits_reg[1]  <= 4'd5;
            digits_reg[2]  <= 4'd0;
            digits_reg[3]  <= 4'd0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_index_reg <= scan_index_next;
            tick_count_reg <= tick_count_next;
            tps_reg        <= tps_next;
            remaining_reg  <= remaining_next;
            digits_reg     <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mins_reg  <= mins_next;
        secs_reg  <= secs_next;
        mtens_reg <= mtens_next;
        stens_reg <= stens_next;
    end

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cmds_pkg::CONV_IDLE) |-> !in_ready)
        else $error("Input taken while the digit conversion is running.");

endmodule

/* hw/rtl/cmds_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter queue
// Two-entry queue of scan words between the front end and the shifter.
// ----------------------------------------------------------------------------
module cmds_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cmds_pkg::cmds_item_t push_item,
    output logic                 q_ready,
    input  logic                 pop,
    output logic                 q_valid,
    output cmds_pkg::cmds_item_t head_item
);

    cmds_pkg::cmds_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_ready   = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == 2'd2)))
        else $error("Queue written while full.");

endmodule

/* hw/rtl/cmds_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter back end
// Shifts each queued scan word out as sixteen beats, MSB first.
// ----------------------------------------------------------------------------
module cmds_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cmds_pkg::cmds_item_t        head_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        serial_bit,
    output logic                        latch_now,
    output logic [cmds_pkg::POS_W-1:0]  scan_position,
    output logic [cmds_pkg::SECS_W-1:0] seconds_left
);

    logic                        busy_reg, busy_next;
    logic [cmds_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cmds_pkg::WORD_W-1:0] word_reg, word_next;
    logic [cmds_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [cmds_pkg::SECS_W-1:0] secs_reg, secs_next;
    logic                        beat;
    logic                        last_beat;

    assign out_valid     = busy_reg;
    assign serial_bit    = word_reg[cmds_pkg::WORD_W-1];
    assign latch_now     = (cnt_reg == cmds_pkg::LAST_BIT);
    assign scan_position = pos_reg;
    assign seconds_left  = secs_reg;

    assign beat      = busy_reg && out_ready;
    assign last_beat = beat && latch_now;
    assign pop       = q_valid && (!busy_reg || last_beat);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        word_next = word_reg;
        pos_next  = pos_reg;
        secs_next = secs_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            word_next = head_item.word;
            pos_next  = head_item.pos;
            secs_next = head_item.secs;
        end
        else if (last_beat)
        begin
            busy_next = 1'b0;
            cnt_next  = '0;
        end
        else if (beat)
        begin
            cnt_next  = cnt_reg + 4'd1;
            word_next = {word_reg[cmds_pkg::WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        pos_reg  <= pos_next;
        secs_reg <= secs_next;
    end

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !latch_now) |=> (out_valid && (cnt_reg == $past(cnt_reg) + 4'd1)))
        else $error("Run broke off before its sixteenth beat.");

    a_run_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        last_beat |=> (cnt_reg == '0))
        else $error("Beat counter did not restart after the latch beat.");

endmodule

/* dv/countdown_mux_display_shifter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown display shifter testbench
// Drives ticks and register writes into the multiplexed countdown display
// shifter and tracks its scan position, tick count and remaining seconds.
// Every set tick is expanded into the sixteen expected serial beats. Each output
// beat is checked field by field against the oldest expected beat. Both
// handshakes idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module countdown_mux_display_shifter_tb;

    localparam int NUM_POS     = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 24;

    typedef struct {
        logic                        data_bit;
        logic                        latch;
        logic [cmds_pkg::POS_W-1:0]  pos;
        logic [cmds_pkg::SECS_W-1:0] secs;
    } beat_t;

    class countdown_scoreboard;
        beat_t                       expected_beats[$];
        logic [cmds_pkg::TPS_W-1:0]  rate;
        logic [cmds_pkg::POS_W-1:0]  scan;
        logic [cmds_pkg::TPS_W-1:0]  ticks_into_second;
        logic [cmds_pkg::SECS_W-1:0] remaining_secs;
        logic [3:0]                  digit [4];
        int                          errors;
        int                          beats_checked;
        int                          countdown_steps;

        function void reset_state();
            rate              = cmds_pkg::RESET_TPS;
            scan              = '0;
            ticks_into_second = '0;
            remaining_secs    = cmds_pkg::RESET_START;
            refresh_digits();
        endfunction

        function void refresh_digits();
            int mins;
            int secs;
            mins     = int'(remaining_secs) / 60;
            secs     = int'(remaining_secs) % 60;
            digit[0] = 4'((mins / 10) % 10);
            digit[1] = 4'(mins % 10);
            digit[2] = 4'(secs / 10);
            digit[3] = 4'(secs % 10);
        endfunction

        function logic [7:0] segments_for(logic [3:0] d);
            case (d)
                4'd1:    return 8'hF9;
                4'd2:    return 8'hA4;
                4'd3:    return 8'hB0;
                4'd4:    return 8'h99;
                4'd5:    return 8'h92;
                4'd6:    return 8'h82;
                4'd7:    return 8'hF8;
                4'd8:    return 8'h80;
                4'd9:    return 8'h90;
                default: return 8'hC0;
            endcase
        endfunction

        function void write_reg(logic idx, logic [cmds_pkg::CFG_W-1:0] data);
            if (idx == cmds_pkg::CFG_START_SECONDS)
            begin
                remaining_secs = (data[cmds_pkg::SECS_W-1:0] > cmds_pkg::MAX_START)
                                 ? cmds_pkg::MAX_START : data[cmds_pkg::SECS_W-1:0];
                refresh_digits();
            end
            else
            begin
                rate = data;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_tick(logic t);
            beat_t                       b;
            logic [7:0]                  seg;
            logic [cmds_pkg::WORD_W-1:0] word;
            logic [cmds_pkg::TPS_W-1:0]  limit;
            int                          k;
            if (!t)
                return;
            seg  = (scan < 3'd4) ? segments_for(digit[scan[1:0]]) : cmds_pkg::BLANK_SEG;
            word = {~(8'h01 << scan), seg};
            for (k = 0; k < cmds_pkg::WORD_W; k++)
            begin
                b.data_bit = word[cmds_pkg::WORD_W-1-k];
                b.latch    = (k == cmds_pkg::WORD_W - 1);
                b.pos      = scan;
                b.secs     = remaining_secs;
                expected_beats.push_back(b);
            end
            scan              = (scan == cmds_pkg::POS_W'(NUM_POS - 1)) ? '0 : scan + 3'd1;
            ticks_into_second = ticks_into_second + 16'd1;
            limit             = (rate == '0) ? 16'd1 : rate;
            if (ticks_into_second >= limit || ticks_into_second == '0)
            begin
                ticks_into_second = '0;
                if (remaining_secs != '0)
                begin
                    remaining_secs = remaining_secs - 13'd1;
                    countdown_steps++;
                    refresh_digits();
                end
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH %s: got %0d expected %0d (beat %0d, t=%0t)",
                         what, got, want, beats_checked, $realtime);
        endtask

        task check_beat(logic sb, logic lt, logic [cmds_pkg::POS_W-1:0] pos,
                        logic [cmds_pkg::SECS_W-1:0] secs);
            beat_t want;
            if (expected_beats.size() == 0)
            begin
                report_mismatch("beat with nothing expected", int'(sb), -1);
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (sb !== want.data_bit)
                report_mismatch("serial_bit", int'(sb), int'(want.data_bit));
            if (lt !== want.latch)
                report_mismatch("latch_now", int'(lt), int'(want.latch));
            if (pos !== want.pos)
                report_mismatch("scan_position", int'(pos), int'(want.pos));
            if (secs !== want.secs)
                report_mismatch("seconds_left", int'(secs), int'(want.secs));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [cmds_pkg::CFG_W-1:0]  cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        tick;
    logic                        out_valid;
    logic                        out_ready;
    logic                        serial_bit;
    logic                        latch_now;
    logic [cmds_pkg::POS_W-1:0]  scan_position;
    logic [cmds_pkg::SECS_W-1:0] seconds_left;

    countdown_scoreboard tracker;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;
    int                  cycle_count;
    int                  ticks_sent;
    int                  idles_sent;
    int                  reg_writes;

    countdown_mux_display_shifter #(
        .NUM_POSITIONS (NUM_POS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_bit    (serial_bit),
        .latch_now     (latch_now),
        .scan_position (scan_position),
        .seconds_left  (seconds_left)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, tracker.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: checks beats at the rising edge, changes ready at the falling edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_beat(serial_bit, latch_now, scan_position, seconds_left);
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_tick(t);
        if (t)
            ticks_sent++;
        else
            idles_sent++;
    endtask

    task automatic write_cfg(input logic idx, input logic [cmds_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drops valid, drains every expected beat, then lets the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure_random();
        logic [cmds_pkg::CFG_W-1:0] secs_word;
        logic [cmds_pkg::CFG_W-1:0] rate_word;
        case ($urandom_range(3))
            0:       secs_word = cmds_pkg::CFG_W'($urandom_range(5999));
            1:       secs_word = cmds_pkg::CFG_W'($urandom_range(90));
            2:       secs_word = cmds_pkg::CFG_W'(cmds_pkg::MAX_START);
            default: secs_word = cmds_pkg::CFG_W'($urandom);
        endcase
        case ($urandom_range(4))
            0, 1, 2: rate_word = cmds_pkg::CFG_W'($urandom_range(3, 1));
            3:       rate_word = cmds_pkg::CFG_W'($urandom_range(65535, 4));
            default: rate_word = '0;
        endcase
        if ($urandom_range(1) == 1)
        begin
            write_cfg(cmds_pkg::CFG_START_SECONDS, secs_word);
            write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, rate_word);
        end
        else
        begin
            write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, rate_word);
            write_cfg(cmds_pkg::CFG_START_SECONDS, secs_word);
        end
    endtask

    task automatic run_block(input int send_pct, input int recv_pct, input int n_ticks,
                             input bit long_hold);
        int sent;
        sent = 0;
        wait_idle();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        configure_random();
        while (sent < n_ticks)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(1'b0);
            end
            else
            begin
                send_item(1'b1);
                sent++;
                if (long_hold && sent == 3)
                    hold_left = 320;
            end
        end
    endtask

    initial
    begin
        tracker        = new();
        tracker.reset_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cycle_count    = 0;
        ticks_sent     = 0;
        idles_sent     = 0;
        reg_writes     = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = cmds_pkg::CFG_START_SECONDS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        tick           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset value 05:00 over a full scan with wrap, idle inputs around it.
        send_item(1'b0);
        repeat (9) send_item(1'b1);
        send_item(1'b0);
        wait_idle();
        // The rate drops below the ticks already counted, so the next tick
        // completes a second.
        write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, 16'd5);
        repeat (2) send_item(1'b1);
        wait_idle();
        // An all-ones start value saturates to 99:59; a zero rate counts
        // a second on every tick.
        write_cfg(cmds_pkg::CFG_START_SECONDS, 16'hFFFF);
        write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, 16'h0000);
        repeat (6) send_item(1'b1);
        wait_idle();
        // Bits above the register width are dropped; the count runs into
        // zero and holds there.
        write_cfg(cmds_pkg::CFG_START_SECONDS, 16'h2002);
        write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, 16'd1);
        repeat (5) send_item(1'b1);
        wait_idle();
        write_cfg(cmds_pkg::CFG_START_SECONDS, 16'd0);
        write_cfg(cmds_pkg::CFG_TICKS_PER_SECOND, 16'hFFFF);
        repeat (2) send_item(1'b1);

        run_block(0, 0, 17, 1'b0);
        run_block(0, 0, 17, 1'b0);
        run_block(69, 0, 17, 1'b0);
        run_block(69, 0, 17, 1'b0);
        run_block(0, 69, 17, 1'b0);
        run_block(0, 69, 17, 1'b0);
        run_block(32, 32, 17, 1'b0);
        run_block(32, 32, 17, 1'b0);
        run_block(0, 0, 17, 1'b1);
        run_block(0, 0, 17, 1'b0);
        wait_idle();

        $display("Run covered %0d ticks and %0d idle inputs, %0d register writes,",
                 ticks_sent, idles_sent, reg_writes);
        $display("%0d serial beats checked and %0d countdown steps, %0d mismatches.",
                 tracker.beats_checked, tracker.countdown_steps, tracker.errors);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
